// ===== sv/lgp_pkg.sv =====
// Shared types, constants and helpers for the linear gradient pixel generator.
`timescale 1ns / 1ps
`default_nettype none
package lgp_pkg;

   localparam int MAX_SIDE   = 4096;
   localparam int MAX_STOPS  = 4;
   localparam int SIDE_W     = 13;
   localparam int POS_W      = 12;
   localparam int LEN_W      = SIDE_W + 1;
   localparam int THR_W      = LEN_W + 1;
   localparam int NUM_W      = POS_W + SIDE_W;
   localparam int COEF_W     = 26;
   localparam int PROD_W     = COEF_W + LEN_W + 1;
   localparam int STOP_W     = 48;
   localparam int CHAN_W     = 16;
   localparam int PIX_W      = 8;
   localparam int CHAN_COUNT = 3;
   localparam int SEG_COUNT  = 3;
   localparam int SIDE_CAP   = (MAX_SIDE > (2 ** SIDE_W) - 1) ? (2 ** SIDE_W) - 1 : MAX_SIDE;
   // Clamp, product, one stage per quotient bit, index, segment, multiply, output.
   localparam int LATENCY    = SIDE_W + 6;

   localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [2:0] REG_DIRECTION    = 3'd2;
   localparam logic [2:0] REG_STOP_COUNT   = 3'd3;
   localparam logic [2:0] REG_STOP_ZERO    = 3'd4;
   localparam logic [2:0] REG_STOP_ONE     = 3'd5;
   localparam logic [2:0] REG_STOP_TWO     = 3'd6;
   localparam logic [2:0] REG_STOP_THREE   = 3'd7;

   typedef enum logic [1:0] {
      DIR_HORIZ,
      DIR_VERT,
      DIR_DIAG
   } lgp_dir_type;

   typedef logic signed [COEF_W-1:0] lgp_coef_type;

   typedef struct packed {
      logic [SIDE_W-1:0] w_max;
      logic [SIDE_W-1:0] h_max;
      lgp_dir_type       dir;
      logic [THR_W-1:0]  lim;
      logic [THR_W-1:0]  t1;
      logic [THR_W-1:0]  t2;
      lgp_coef_type [SEG_COUNT-1:0][CHAN_COUNT-1:0] base;
      lgp_coef_type [SEG_COUNT-1:0][CHAN_COUNT-1:0] delta;
      lgp_coef_type [CHAN_COUNT-1:0]                fill;
   } lgp_line_type;

   // Channel 0 is red in the top bits, channel 2 blue in the bottom bits.
   function automatic logic [CHAN_W-1:0] chan16(input logic [STOP_W-1:0] stop,
                                                input logic [1:0] ch);
      logic [CHAN_W-1:0] c;
      case (ch)
         2'd0:    c = stop[47:32];
         2'd1:    c = stop[31:16];
         default: c = stop[15:0];
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== sv/lgp_divider.sv =====
// Iterative signed-by-unsigned divider with truncation towards zero.
`timescale 1ns / 1ps
`default_nettype none
module lgp_divider (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire lgp_pkg::lgp_coef_type      dividend,
   input  wire logic [lgp_pkg::LEN_W-1:0]  divisor,
   output logic                            done,
   output lgp_pkg::lgp_coef_type           quotient
);
   import lgp_pkg::*;

   localparam int CNT_W = $clog2(COEF_W + 1);

   logic [CNT_W-1:0]  count_ff;
   logic              run_ff;
   logic              done_ff;
   logic              neg_ff;
   logic [COEF_W-1:0] mag_ff;
   logic [LEN_W-1:0]  rem_ff;
   logic [LEN_W-1:0]  div_ff;
   logic [LEN_W:0]    trial;
   logic              ge;

   assign trial = {rem_ff, mag_ff[COEF_W-1]};
   assign ge    = trial >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
      end else if (start) begin
         count_ff <= CNT_W'(COEF_W);
         run_ff   <= 1'b1;
         done_ff  <= 1'b0;
      end else if (run_ff) begin
         count_ff <= count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[COEF_W-1];
         mag_ff <= dividend[COEF_W-1] ? COEF_W'(-dividend) : dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (run_ff) begin
         rem_ff <= ge ? LEN_W'(trial - {1'b0, div_ff}) : trial[LEN_W-1:0];
         mag_ff <= {mag_ff[COEF_W-2:0], ge};
      end
   end

   // A new start hides a finish left over from an abandoned run.
   assign done     = done_ff && !start;
   assign quotient = neg_ff ? -$signed(mag_ff) : $signed(mag_ff);

endmodule
`default_nettype wire

// ===== sv/lgp_setup.sv =====
// Configuration registers and the sequencer that derives the line coefficients.
`timescale 1ns / 1ps
`default_nettype none
module lgp_setup (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_write_enable,
   input  wire logic [2:0]                  csr_index,
   input  wire logic [lgp_pkg::STOP_W-1:0]  csr_write_data,
   output logic                             busy,
   output lgp_pkg::lgp_line_type            line
);
   import lgp_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SEG_WAIT,
      ST_DELTA,
      ST_DELTA_WAIT,
      ST_FINISH
   } state_type;

   state_type         state_ff;
   logic [SIDE_W-1:0] width_ff;
   logic [SIDE_W-1:0] height_ff;
   logic [1:0]        direction_ff;
   logic [2:0]        stop_count_ff;
   logic [STOP_W-1:0] stop_ff [MAX_STOPS];

   logic [LEN_W-1:0]  len_ff;
   logic [LEN_W-1:0]  seg_ff;
   logic [2:0]        nn_ff;
   logic              simple_ff;
   logic [1:0]        s_ff;
   logic [1:0]        c_ff;
   lgp_line_type      line_ff;
   logic              div_start_ff;
   lgp_coef_type      dividend_ff;
   logic [LEN_W-1:0]  divisor_ff;

   logic              div_done;
   lgp_coef_type      div_quotient;

   logic [SIDE_W-1:0] p_w;
   logic [SIDE_W-1:0] p_h;
   logic [2:0]        p_n;
   lgp_dir_type       p_dir;
   logic              p_multi;
   logic [LEN_W-1:0]  p_len;
   logic [LEN_W-1:0]  p_seg_div;
   lgp_coef_type      delta_num;
   logic [CHAN_W-1:0] ca;
   logic [CHAN_W-1:0] cb;
   logic [7:0]        a8;
   logic [7:0]        b8;

   always_comb begin
      p_w = (width_ff == '0) ? SIDE_W'(1) :
            (width_ff > SIDE_W'(SIDE_CAP)) ? SIDE_W'(SIDE_CAP) : width_ff;
      p_h = (height_ff == '0) ? SIDE_W'(1) :
            (height_ff > SIDE_W'(SIDE_CAP)) ? SIDE_W'(SIDE_CAP) : height_ff;
      p_n = (stop_count_ff == '0) ? 3'd1 :
            (stop_count_ff > 3'(MAX_STOPS)) ? 3'(MAX_STOPS) : stop_count_ff;
      unique case (direction_ff)
         2'd0:    p_dir = DIR_HORIZ;
         2'd1:    p_dir = DIR_VERT;
         default: p_dir = DIR_DIAG;
      endcase
      if (p_dir == DIR_DIAG && p_w == SIDE_W'(1)) begin
         p_dir = DIR_VERT;
      end else if (p_dir == DIR_DIAG && p_h == SIDE_W'(1)) begin
         p_dir = DIR_HORIZ;
      end
      p_multi = p_n > 3'd2;
      unique case (p_dir)
         DIR_HORIZ: p_len = {1'b0, p_w};
         DIR_VERT:  p_len = {1'b0, p_h};
         default:   p_len = {p_w, 1'b0} - LEN_W'(1);
      endcase
      // The diagonal limits the stop count by both sides and may fall back.
      if (p_dir == DIR_DIAG && p_multi) begin
         if (SIDE_W'(p_n) > p_w) p_n = p_w[2:0];
         if (SIDE_W'(p_n) > p_h) p_n = p_h[2:0];
         p_multi = p_n > 3'd2;
      end
      if (p_multi && LEN_W'(p_n) > p_len) p_n = p_len[2:0];
      p_seg_div = (p_multi && p_n > 3'd1) ? LEN_W'(p_n - 3'd1) : LEN_W'(1);

      ca = chan16(stop_ff[s_ff], c_ff);
      cb = chan16(stop_ff[2'(s_ff + 2'd1)], c_ff);
      a8 = 8'(chan16(stop_ff[0], c_ff) >> 8);
      b8 = 8'(chan16((nn_ff >= 3'd2) ? stop_ff[1] : stop_ff[0], c_ff) >> 8);
      if (simple_ff) begin
         delta_num = ($signed(COEF_W'(b8)) - $signed(COEF_W'(a8))) <<< 16;
      end else begin
         delta_num = ($signed(COEF_W'(cb)) - $signed(COEF_W'(ca))) <<< 8;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= SIDE_W'(1);
         height_ff     <= SIDE_W'(1);
         direction_ff  <= 2'd0;
         stop_count_ff <= 3'd2;
         for (int i = 0; i < MAX_STOPS; i++) stop_ff[i] <= '0;
         state_ff      <= ST_PREP;
         div_start_ff  <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         if (csr_write_enable) begin
            unique case (csr_index)
               REG_IMAGE_WIDTH:  width_ff      <= csr_write_data[SIDE_W-1:0];
               REG_IMAGE_HEIGHT: height_ff     <= csr_write_data[SIDE_W-1:0];
               REG_DIRECTION:    direction_ff  <= csr_write_data[1:0];
               REG_STOP_COUNT:   stop_count_ff <= csr_write_data[2:0];
               REG_STOP_ZERO:    stop_ff[0]    <= csr_write_data;
               REG_STOP_ONE:     stop_ff[1]    <= csr_write_data;
               REG_STOP_TWO:     stop_ff[2]    <= csr_write_data;
               REG_STOP_THREE:   stop_ff[3]    <= csr_write_data;
            endcase
            state_ff <= ST_PREP;
         end else begin
            unique case (state_ff)
               ST_IDLE: begin
               end
               ST_PREP: begin
                  line_ff.w_max <= p_w - SIDE_W'(1);
                  line_ff.h_max <= p_h - SIDE_W'(1);
                  line_ff.dir   <= p_dir;
                  len_ff        <= p_len;
                  nn_ff         <= p_n;
                  simple_ff     <= !p_multi;
                  dividend_ff   <= COEF_W'(p_len);
                  divisor_ff    <= p_seg_div;
                  div_start_ff  <= 1'b1;
                  state_ff      <= ST_SEG_WAIT;
               end
               ST_SEG_WAIT: begin
                  if (div_done) begin
                     seg_ff   <= div_quotient[LEN_W-1:0];
                     s_ff     <= 2'd0;
                     c_ff     <= 2'd0;
                     state_ff <= ST_DELTA;
                  end
               end
               ST_DELTA: begin
                  dividend_ff  <= delta_num;
                  divisor_ff   <= simple_ff ? len_ff : seg_ff;
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_DELTA_WAIT;
               end
               ST_DELTA_WAIT: begin
                  if (div_done) begin
                     line_ff.delta[s_ff][c_ff] <= div_quotient;
                     if (c_ff == 2'(CHAN_COUNT - 1)) begin
                        c_ff <= 2'd0;
                        if (s_ff == 2'(SEG_COUNT - 1)) begin
                           state_ff <= ST_FINISH;
                        end else begin
                           s_ff     <= s_ff + 2'd1;
                           state_ff <= ST_DELTA;
                        end
                     end else begin
                        c_ff     <= c_ff + 2'd1;
                        state_ff <= ST_DELTA;
                     end
                  end
               end
               ST_FINISH: begin
                  if (simple_ff) begin
                     line_ff.t1  <= '1;
                     line_ff.t2  <= '1;
                     line_ff.lim <= '1;
                     for (int s = 0; s < SEG_COUNT; s++) begin
                        for (int c = 0; c < CHAN_COUNT; c++) begin
                           line_ff.base[s][c] <= $signed(COEF_W'({
                              chan16(stop_ff[0], 2'(c)) >> 8, 16'h0000}));
                        end
                     end
                     for (int c = 0; c < CHAN_COUNT; c++) line_ff.fill[c] <= '0;
                  end else begin
                     line_ff.t1 <= THR_W'(seg_ff);
                     line_ff.t2 <= {seg_ff, 1'b0};
                     unique case (nn_ff)
                        3'd2:    line_ff.lim <= THR_W'(seg_ff);
                        3'd3:    line_ff.lim <= {seg_ff, 1'b0};
                        3'd4:    line_ff.lim <= THR_W'(seg_ff) + {seg_ff, 1'b0};
                        default: line_ff.lim <= '0;
                     endcase
                     for (int s = 0; s < SEG_COUNT; s++) begin
                        for (int c = 0; c < CHAN_COUNT; c++) begin
                           line_ff.base[s][c] <= $signed({2'b00,
                              chan16(stop_ff[s], 2'(c)), 8'h00});
                        end
                     end
                     for (int c = 0; c < CHAN_COUNT; c++) begin
                        line_ff.fill[c] <= $signed({2'b00,
                           chan16(stop_ff[2'(nn_ff - 3'd1)], 2'(c)), 8'h00});
                     end
                  end
                  state_ff <= ST_IDLE;
               end
            endcase
         end
      end
   end

   lgp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (dividend_ff),
      .divisor  (divisor_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign busy = state_ff != ST_IDLE;
   assign line = line_ff;

endmodule
`default_nettype wire

// ===== sv/lgp_pixel_pipe.sv =====
// Pixel pipeline: clamp, diagonal offset division, segment pick and interpolation.
`timescale 1ns / 1ps
`default_nettype none
module lgp_pixel_pipe (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire logic [lgp_pkg::POS_W-1:0]  pos_x,
   input  wire logic [lgp_pkg::POS_W-1:0]  pos_y,
   input  wire lgp_pkg::lgp_line_type      line,
   output logic                            out_valid,
   output logic [lgp_pkg::PIX_W-1:0]       red,
   output logic [lgp_pkg::PIX_W-1:0]       green,
   output logic [lgp_pkg::PIX_W-1:0]       blue
);
   import lgp_pkg::*;

   localparam int Q_W = SIDE_W;

   // Clamp stage.
   logic             v1_ff;
   logic [POS_W-1:0] x1_ff;
   logic [POS_W-1:0] y1_ff;
   logic [POS_W-1:0] x_c_in;
   logic [POS_W-1:0] y_c_in;
   logic [NUM_W-1:0] num_in;

   assign x_c_in = ({1'b0, pos_x} > line.w_max) ? line.w_max[POS_W-1:0] : pos_x;
   assign y_c_in = ({1'b0, pos_y} > line.h_max) ? line.h_max[POS_W-1:0] : pos_y;
   assign num_in = NUM_W'(y1_ff) * NUM_W'(line.w_max);

   always_ff @(posedge clock) begin
      v1_ff <= reset ? 1'b0 : in_valid;
      x1_ff <= x_c_in;
      y1_ff <= y_c_in;
   end

   // One quotient bit of y*(W-1)/(H-1) per stage.
   logic             dv_ff  [Q_W+1];
   logic [Q_W-1:0]   rem_ff [Q_W+1];
   logic [Q_W-1:0]   q_ff   [Q_W+1];
   logic [NUM_W-1:0] num_ff [Q_W+1];
   logic [POS_W-1:0] x_ff   [Q_W+1];
   logic [POS_W-1:0] y_ff   [Q_W+1];
   logic [Q_W:0]     trial  [Q_W];
   logic             ge     [Q_W];
   logic [Q_W-1:0]   rem_in [Q_W];
   logic [Q_W-1:0]   q_in   [Q_W];

   always_comb begin
      for (int i = 0; i < Q_W; i++) begin
         trial[i]  = {rem_ff[i], num_ff[i][Q_W-1-i]};
         ge[i]     = trial[i] >= {1'b0, line.h_max};
         rem_in[i] = ge[i] ? Q_W'(trial[i] - {1'b0, line.h_max}) : trial[i][Q_W-1:0];
         q_in[i]   = q_ff[i];
         q_in[i][Q_W-1-i] = ge[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= Q_W; i++) dv_ff[i] <= 1'b0;
      end else begin
         dv_ff[0] <= v1_ff;
         for (int i = 0; i < Q_W; i++) dv_ff[i+1] <= dv_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= Q_W'(num_in[NUM_W-1:Q_W]);
      q_ff[0]   <= '0;
      num_ff[0] <= num_in;
      x_ff[0]   <= x1_ff;
      y_ff[0]   <= y1_ff;
      for (int i = 0; i < Q_W; i++) begin
         rem_ff[i+1] <= rem_in[i];
         q_ff[i+1]   <= q_in[i];
         num_ff[i+1] <= num_ff[i];
         x_ff[i+1]   <= x_ff[i];
         y_ff[i+1]   <= y_ff[i];
      end
   end

   // Line index, segment pick, multiply and add.
   logic                    vi_ff, vs_ff, vm_ff, out_valid_ff;
   logic [LEN_W-1:0]        idx_in, idx_ff;
   logic [THR_W-1:0]        idx_w;
   logic [1:0]              s_in, s_ff;
   logic [LEN_W-1:0]        j_in, j_ff;
   logic                    fill_in, fill_ff;
   logic signed [PROD_W-1:0] prod_in [CHAN_COUNT];
   logic signed [PROD_W-1:0] prod_ff [CHAN_COUNT];
   lgp_coef_type            base_in [CHAN_COUNT];
   lgp_coef_type            base_ff [CHAN_COUNT];
   logic signed [PROD_W-1:0] sum    [CHAN_COUNT];
   logic [PIX_W-1:0]        pix_ff  [CHAN_COUNT];

   always_comb begin
      unique case (line.dir)
         DIR_HORIZ: idx_in = LEN_W'(x_ff[Q_W]);
         DIR_VERT:  idx_in = LEN_W'(y_ff[Q_W]);
         default:   idx_in = LEN_W'(x_ff[Q_W]) + LEN_W'(q_ff[Q_W]);
      endcase
   end

   assign idx_w = THR_W'(idx_ff);

   always_comb begin
      fill_in = 1'b0;
      priority if (idx_w >= line.lim) begin
         fill_in = 1'b1;
         s_in    = 2'd0;
         j_in    = '0;
      end else if (idx_w >= line.t2) begin
         s_in = 2'd2;
         j_in = LEN_W'(idx_w - line.t2);
      end else if (idx_w >= line.t1) begin
         s_in = 2'd1;
         j_in = LEN_W'(idx_w - line.t1);
      end else begin
         s_in = 2'd0;
         j_in = idx_ff;
      end
   end

   always_comb begin
      for (int c = 0; c < CHAN_COUNT; c++) begin
         prod_in[c] = $signed({1'b0, j_ff}) * $signed(line.delta[s_ff][c]);
         base_in[c] = fill_ff ? line.fill[c] : line.base[s_ff][c];
         sum[c]     = prod_ff[c] + $signed(base_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vi_ff        <= 1'b0;
         vs_ff        <= 1'b0;
         vm_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         vi_ff        <= dv_ff[Q_W];
         vs_ff        <= vi_ff;
         vm_ff        <= vs_ff;
         out_valid_ff <= vm_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      s_ff    <= s_in;
      j_ff    <= j_in;
      fill_ff <= fill_in;
      for (int c = 0; c < CHAN_COUNT; c++) begin
         prod_ff[c] <= prod_in[c];
         base_ff[c] <= base_in[c];
         pix_ff[c]  <= sum[c][23:16];
      end
   end

   assign out_valid = out_valid_ff;
   assign red       = pix_ff[0];
   assign green     = pix_ff[1];
   assign blue      = pix_ff[2];

endmodule
`default_nettype wire

// ===== sv/linear_gradient_pixel_generator.sv =====
// Top level of the linear gradient pixel generator.
//
// A transaction is a pixel position on req_pos_x and req_pos_y, taken at a
// rising edge where start is high and busy is low. Its colour appears on
// rsp_red, rsp_green and rsp_blue for exactly one cycle, marked by rsp_valid,
// and is taken at the edge that ends that cycle; the receiver cannot stall.
// A new position may be started in every cycle while busy is low: one pixel
// per clock. A result passes the clamp stage, a product stage, one stage
// per bit of the 13-bit diagonal quotient, then index, segment, multiply and
// output stages.
// Registers are written through csr_write_enable, csr_index and
// csr_write_data; the user must write them only while no transaction is in
// flight, which the block itself does not enforce. After reset and after
// every write, busy stays high while the segment length and the nine colour
// steps are worked out by a shared iterative divider, 26 iterations for each
// quotient. Reset is synchronous and restores the register defaults, clears
// the pipeline and starts that setup pass.
`timescale 1ns / 1ps
`default_nettype none
module linear_gradient_pixel_generator (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [lgp_pkg::POS_W-1:0]   req_pos_x,
   input  wire logic [lgp_pkg::POS_W-1:0]   req_pos_y,
   output logic                             rsp_valid,
   output logic [lgp_pkg::PIX_W-1:0]        rsp_red,
   output logic [lgp_pkg::PIX_W-1:0]        rsp_green,
   output logic [lgp_pkg::PIX_W-1:0]        rsp_blue,
   input  wire logic                        csr_write_enable,
   input  wire logic [2:0]                  csr_index,
   input  wire logic [lgp_pkg::STOP_W-1:0]  csr_write_data
);
   import lgp_pkg::*;

   lgp_line_type line;
   logic         accept;

   assign accept = start && !busy;

   lgp_setup u_setup (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .busy             (busy),
      .line             (line)
   );

   lgp_pixel_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .pos_x     (req_pos_x),
      .pos_y     (req_pos_y),
      .line      (line),
      .out_valid (rsp_valid),
      .red       (rsp_red),
      .green     (rsp_green),
      .blue      (rsp_blue)
   );

`ifndef SYNTH
   // Every result goes back to a transaction started a fixed latency earlier.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result without a matching start");

   // A register write always triggers a fresh setup pass.
   assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> busy)
      else $error("busy not raised after a register write");
`endif

endmodule
`default_nettype wire
